// File: hdl/sma_pkg.sv
`timescale 1ns / 1ps

package sma_pkg;

	typedef logic signed [31:0] data_t;

	typedef enum logic [2:0] {
		OP_PUSH = 3'd0,
		OP_ADD  = 3'd1,
		OP_SUB  = 3'd2,
		OP_MUL  = 3'd3,
		OP_DUMP = 3'd4,
		OP_FAIL = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		ST_OK            = 3'd0,
		ST_DUMPED        = 3'd1,
		ST_INVALID_TOKEN = 3'd2,
		ST_OTHER_FAIL    = 3'd3,
		ST_UNKNOWN       = 3'd4,
		ST_UNDERFLOW     = 3'd5,
		ST_OVERFLOW      = 3'd6,
		ST_HALTED        = 3'd7
	} status_t;

	// Stack update chosen by the execute logic
	typedef enum logic [1:0] {
		ACT_NONE    = 2'd0,
		ACT_PUSH    = 2'd1,
		ACT_REPLACE = 2'd2,
		ACT_POP     = 2'd3
	} stack_act_t;

	typedef struct packed {
		stack_act_t act;
		logic       halt;
		data_t      data;
	} stack_ctl_t;

	localparam data_t INVALID_TOKEN_CODE = 32'sd100;

endpackage

// File: hdl/sma_if.sv
`timescale 1ns / 1ps

interface sma_cmd_if;
	logic                 valid;
	logic                 ready;
	logic [2:0]           op;
	sma_pkg::data_t       operand;

	modport source (output valid, output op, output operand, input ready);
	modport sink (input valid, input op, input operand, output ready);
endinterface

interface sma_rsp_if;
	logic                 valid;
	logic                 ready;
	logic [2:0]           status;
	sma_pkg::data_t       dump_value;
	logic [6:0]           depth;

	modport source (output valid, output status, output dump_value, output depth,
		input ready);
	modport sink (input valid, input status, input dump_value, input depth,
		output ready);
endinterface

// File: hdl/sma_exec.sv
`timescale 1ns / 1ps

module sma_exec #(
	parameter int STACK_DEPTH = 64
) (
	input  logic [2:0]                        op,
	input  sma_pkg::data_t                    operand,
	input  logic [$clog2(STACK_DEPTH+1)-1:0]  depth,
	input  logic                              halted,
	input  sma_pkg::data_t                    top,
	input  sma_pkg::data_t                    sec,
	output sma_pkg::stack_ctl_t               ctl,
	output sma_pkg::status_t                  status,
	output sma_pkg::data_t                    dump_value,
	output logic [$clog2(STACK_DEPTH+1)-1:0]  depth_next
);
	import sma_pkg::*;

	localparam int DW = $clog2(STACK_DEPTH + 1);
	localparam logic [DW-1:0] FULL = DW'(STACK_DEPTH);

	data_t alu_r;

	always_comb begin
		case (op_t'(op))
			OP_ADD:  alu_r = sec + top;
			OP_SUB:  alu_r = sec - top;
			default: alu_r = 32'(sec * top);
		endcase
	end

	always_comb begin
		ctl.act    = ACT_NONE;
		ctl.halt   = 1'b0;
		ctl.data   = operand;
		status     = ST_OK;
		dump_value = '0;
		depth_next = depth;
		if (halted) begin
			status = ST_HALTED;
		end else begin
			unique case (op_t'(op)) inside
				OP_PUSH: begin
					if (depth >= FULL) begin
						status   = ST_OVERFLOW;
						ctl.halt = 1'b1;
					end else begin
						ctl.act    = ACT_PUSH;
						depth_next = depth + DW'(1);
					end
				end
				OP_ADD, OP_SUB, OP_MUL: begin
					if (depth < DW'(2)) begin
						status   = ST_UNDERFLOW;
						ctl.halt = 1'b1;
					end else begin
						ctl.act    = ACT_REPLACE;
						ctl.data   = alu_r;
						depth_next = depth - DW'(1);
					end
				end
				OP_DUMP: begin
					if (depth == '0) begin
						status   = ST_UNDERFLOW;
						ctl.halt = 1'b1;
					end else begin
						ctl.act    = ACT_POP;
						status     = ST_DUMPED;
						dump_value = top;
						depth_next = depth - DW'(1);
					end
				end
				OP_FAIL: begin
					status   = (operand == INVALID_TOKEN_CODE) ? ST_INVALID_TOKEN
						: ST_OTHER_FAIL;
					ctl.halt = 1'b1;
				end
				default: begin
					status   = ST_UNKNOWN;
					ctl.halt = 1'b1;
				end
			endcase
		end
	end

endmodule

// File: hdl/sma_stack.sv
`timescale 1ns / 1ps

module sma_stack #(
	parameter int STACK_DEPTH = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  sma_pkg::stack_ctl_t               ctl,
	input  logic [$clog2(STACK_DEPTH+1)-1:0]  depth_next,
	output logic [$clog2(STACK_DEPTH+1)-1:0]  depth,
	output logic                              halted,
	output sma_pkg::data_t                    top,
	output sma_pkg::data_t                    sec
);
	import sma_pkg::*;

	localparam int DW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);

	// entries below the top two; entry i of the stack lives at address i
	data_t mem [STACK_DEPTH];

	logic [DW-1:0] depth_q;
	logic          halted_q;
	data_t         top_q;
	data_t         sec_q;
	data_t         rdata_q;
	logic          byp_q;
	data_t         byp_data_q;
	data_t         third;

	logic [DW-1:0] depth_sel;
	logic [DW-1:0] rd_diff;
	logic [DW-1:0] wr_diff;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	logic          wr_en;

	// third entry is read ahead at the depth that will hold next cycle
	assign depth_sel = en ? depth_next : depth_q;
	assign rd_diff   = depth_sel - DW'(3);
	assign rd_addr   = rd_diff[AW-1:0];
	assign wr_diff   = depth_q - DW'(2);
	assign wr_addr   = wr_diff[AW-1:0];
	assign wr_en     = en && (ctl.act == ACT_PUSH);
	assign third     = byp_q ? byp_data_q : rdata_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= sec_q;
		end
		rdata_q <= mem[rd_addr];
	end

	// a push writes the very entry being read ahead: forward it
	always_ff @(posedge clk) begin
		byp_data_q <= sec_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q  <= '0;
			halted_q <= 1'b0;
			byp_q    <= 1'b0;
		end else begin
			byp_q <= wr_en;
			if (en) begin
				depth_q  <= depth_next;
				halted_q <= halted_q | ctl.halt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			case (ctl.act)
				ACT_PUSH: begin
					top_q <= ctl.data;
					sec_q <= top_q;
				end
				ACT_REPLACE: begin
					top_q <= ctl.data;
					sec_q <= third;
				end
				ACT_POP: begin
					top_q <= sec_q;
					sec_q <= third;
				end
				default: ;
			endcase
		end
	end

	assign depth  = depth_q;
	assign halted = halted_q;
	assign top    = top_q;
	assign sec    = sec_q;

endmodule

// File: hdl/stack_machine_alu_unit.sv
`timescale 1ns / 1ps

// Stack calculator: one instruction per transfer on cmd, one result per instruction on rsp.
// A cmd transfer goes through the input register, then the result register, to rsp.
// Throughput: 1 instruction per cycle while rsp is ready; the top two entries sit in
// registers and the third is read ahead from stack memory: no instruction waits on its port.
// Reset (arst_n low, asynchronous): depth zero, halt cleared, both stages empty;
// stack memory contents are not cleared and need no clearing pass.
module stack_machine_alu_unit #(
	parameter int STACK_DEPTH = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	sma_cmd_if.sink   cmd,
	sma_rsp_if.source rsp
);
	import sma_pkg::*;

	localparam int DW = $clog2(STACK_DEPTH + 1);

	// input register
	logic        valid_s1;
	logic [2:0]  op_s1;
	data_t       operand_s1;

	// result register
	logic        valid_s2;
	status_t     status_s2;
	data_t       value_s2;
	logic [6:0]  depth_s2;

	logic          adv;
	stack_ctl_t    ctl;
	status_t       status;
	data_t         dump_value;
	logic [DW-1:0] depth_next;
	logic [DW-1:0] depth;
	logic          halted;
	data_t         top;
	data_t         sec;

	// s1 executes when the result register is free or being emptied this cycle
	assign adv       = valid_s1 && (!valid_s2 || rsp.ready);
	assign cmd.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (cmd.valid && cmd.ready) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (rsp.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			op_s1      <= cmd.op;
			operand_s1 <= cmd.operand;
		end
		if (adv) begin
			status_s2 <= status;
			value_s2  <= dump_value;
			depth_s2  <= 7'(depth_next);   // depth reported on seven bits
		end
	end

	sma_exec #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_exec (
		.op         (op_s1),
		.operand    (operand_s1),
		.depth      (depth),
		.halted     (halted),
		.top        (top),
		.sec        (sec),
		.ctl        (ctl),
		.status     (status),
		.dump_value (dump_value),
		.depth_next (depth_next)
	);

	// stack state only moves when an instruction leaves s1
	sma_stack #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_stack (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (adv),
		.ctl        (ctl),
		.depth_next (depth_next),
		.depth      (depth),
		.halted     (halted),
		.top        (top),
		.sec        (sec)
	);

	assign rsp.valid      = valid_s2;
	assign rsp.status     = status_s2;
	assign rsp.dump_value = value_s2;
	assign rsp.depth      = depth_s2;

endmodule
